FILE: sv/lpht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types and constants of the linear probing hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

   // default sizes, handed to the top level parameters
   localparam int DEF_TABLE_SLOTS  = 64;
   localparam int DEF_PAYLOAD_BITS = 32;

   // field widths
   localparam int KEY_BITS     = 48;
   localparam int ACTION_BITS  = 2;
   localparam int STATUS_BITS  = 2;
   localparam int OUT_PAY_BITS = 32;
   localparam int ENTRY_BITS   = 6;
   localparam int REQ_DATA_BITS = 80;
   localparam int RSP_DATA_BITS = 40;

   // hash mixing constants
   localparam int          HASH_PRE_SHIFT  = 3;
   localparam int          HASH_MIX_SHIFT  = 15;
   localparam int          HASH_POST_SHIFT = 12;
   localparam int          HASH_BITS       = 32;
   localparam logic [31:0] HASH_MULT       = 32'h2c1b3c6d;

   // action codes
   localparam logic [ACTION_BITS-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACTION_BITS-1:0] ACT_LOOKUP = 2'd1;
   localparam logic [ACTION_BITS-1:0] ACT_REMOVE = 2'd2;

   // status codes
   localparam logic [STATUS_BITS-1:0] STS_OK        = 2'd0;
   localparam logic [STATUS_BITS-1:0] STS_NOT_FOUND = 2'd1;
   localparam logic [STATUS_BITS-1:0] STS_FULL      = 2'd2;

   // request into the hash unit
   typedef struct packed {
      logic                valid;
      logic [KEY_BITS-1:0] key;
   } hash_req_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_PROBE,
      ST_SH_READ,
      ST_SH_HASH,
      ST_DONE
   } state_type;

endpackage

FILE: sv/lpht_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_hash
// Two-stage home slot hash: shift/xor mix, constant multiply, xor fold.
// ----------------------------------------------------------------------------
module lpht_hash #(
   parameter int SLOT_BITS = 6
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lpht_pkg::hash_req_type hash_req,
   output logic                   slot_valid,
   output logic [SLOT_BITS-1:0]   slot
);

   logic [lpht_pkg::KEY_BITS-1:0]  shifted;
   logic [lpht_pkg::HASH_BITS-1:0] mix_in;
   logic [lpht_pkg::HASH_BITS-1:0] prod_in;
   logic [lpht_pkg::HASH_BITS-1:0] fold;
   logic [lpht_pkg::HASH_BITS-1:0] mix_ff;
   logic [lpht_pkg::HASH_BITS-1:0] prod_ff;
   logic                           mix_valid_ff;
   logic                           prod_valid_ff;

   // stage 1: drop alignment bits and fold the high part down
   // only the low word matters, the multiply wraps
   assign shifted = hash_req.key >> lpht_pkg::HASH_PRE_SHIFT;
   assign mix_in  = lpht_pkg::HASH_BITS'(shifted ^ (shifted >> lpht_pkg::HASH_MIX_SHIFT));

   // stage 2: constant multiply, low word kept
   assign prod_in = mix_ff * lpht_pkg::HASH_MULT;

   // output fold and mask to the table size
   assign fold       = prod_ff ^ (prod_ff >> lpht_pkg::HASH_POST_SHIFT);
   assign slot       = fold[SLOT_BITS-1:0];
   assign slot_valid = prod_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mix_valid_ff  <= 1'b0;
         prod_valid_ff <= 1'b0;
      end else begin
         mix_valid_ff  <= hash_req.valid;
         prod_valid_ff <= mix_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      mix_ff  <= mix_in;
      prod_ff <= prod_in;
   end

endmodule

FILE: sv/lpht_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_mem
// Slot memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lpht_mem #(
   parameter int SLOT_BITS = 6,
   parameter int WORD_BITS = 81
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [SLOT_BITS-1:0] wr_addr,
   input  logic [WORD_BITS-1:0] wr_data,
   input  logic [SLOT_BITS-1:0] rd_addr,
   output logic [WORD_BITS-1:0] rd_data
);

   logic [WORD_BITS-1:0] mem_ff [2**SLOT_BITS];
   logic [WORD_BITS-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/linear_probe_hash_table.sv
`timescale 1ns / 1ps
// Throughput: one request at a time; the next is taken once the result sits in
//   the output register, so a waiting result does not stall acceptance.
// Reset: synchronous; afterwards a clearing pass over all TABLE_SLOTS slots zeroes
//   the used bits in the slot memory before the first request is taken.
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressing hash table with linear probing and backward shift removal.
// ----------------------------------------------------------------------------
module linear_probe_hash_table #(
   parameter int TABLE_SLOTS  = lpht_pkg::DEF_TABLE_SLOTS,
   parameter int PAYLOAD_BITS = lpht_pkg::DEF_PAYLOAD_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [lpht_pkg::REQ_DATA_BITS-1:0] req_tdata,  // key[47:0], payload[79:48]
   input  logic [lpht_pkg::ACTION_BITS-1:0]   req_tuser,  // action[1:0]
   // response channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [lpht_pkg::RSP_DATA_BITS-1:0] rsp_tdata,  // found_payload[31:0],
                                                          // entries[37:32], zero[39:38]
   output logic [lpht_pkg::STATUS_BITS-1:0]   rsp_tuser   // status[1:0]
);

   localparam int ADDR_BITS = $clog2(TABLE_SLOTS);
   localparam int KEY_BITS  = lpht_pkg::KEY_BITS;
   localparam int WORD_BITS = 1 + KEY_BITS + PAYLOAD_BITS;
   localparam int USED_POS  = WORD_BITS - 1;
   localparam logic [ADDR_BITS-1:0] HALF_LOAD = ADDR_BITS'(TABLE_SLOTS / 2);
   localparam logic [ADDR_BITS-1:0] LAST_SLOT = ADDR_BITS'(TABLE_SLOTS - 1);

   // request fields
   logic [KEY_BITS-1:0]              req_key;
   logic [lpht_pkg::OUT_PAY_BITS-1:0] req_payload;

   assign req_key     = req_tdata[KEY_BITS-1:0];
   assign req_payload = req_tdata[lpht_pkg::REQ_DATA_BITS-1:KEY_BITS];

   // sequencer registers
   lpht_pkg::state_type                state_ff, state_in;
   logic [ADDR_BITS-1:0]               addr_ff, addr_in;
   logic [ADDR_BITS-1:0]               hole_ff, hole_in;
   logic [ADDR_BITS-1:0]               count_ff, count_in;
   logic [lpht_pkg::ACTION_BITS-1:0]   action_ff;
   logic [KEY_BITS-1:0]                key_ff;
   logic [PAYLOAD_BITS-1:0]            pay_ff;
   logic [WORD_BITS-1:0]               ent_ff, ent_in;
   logic [lpht_pkg::STATUS_BITS-1:0]   status_ff, status_in;
   logic [lpht_pkg::OUT_PAY_BITS-1:0]  found_ff, found_in;

   // output register
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [lpht_pkg::STATUS_BITS-1:0]   rsp_status_ff;
   logic [lpht_pkg::OUT_PAY_BITS-1:0]  rsp_found_ff;
   logic [lpht_pkg::ENTRY_BITS-1:0]    rsp_entries_ff;
   logic                               rsp_load;

   // memory and hash connections
   logic                   wr_en;
   logic [ADDR_BITS-1:0]   wr_addr;
   logic [WORD_BITS-1:0]   wr_data;
   logic [WORD_BITS-1:0]   rd_data;
   lpht_pkg::hash_req_type hash_req;
   logic                   slot_valid;
   logic [ADDR_BITS-1:0]   slot;

   // slot word fields as read
   logic                    rd_used;
   logic [KEY_BITS-1:0]     rd_key;
   logic [PAYLOAD_BITS-1:0] rd_pay;
   logic                    stays;
   logic                    accept;

   assign rd_used = rd_data[USED_POS];
   assign rd_key  = rd_data[USED_POS-1:PAYLOAD_BITS];
   assign rd_pay  = rd_data[PAYLOAD_BITS-1:0];

   assign req_tready = (state_ff == lpht_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   // entry at addr stays put when its home lies cyclically in (hole, addr]
   always_comb begin
      if (hole_ff <= addr_ff) begin
         stays = (hole_ff < slot) && (slot <= addr_ff);
      end else begin
         stays = (hole_ff < slot) || (slot <= addr_ff);
      end
   end

   lpht_hash #(
      .SLOT_BITS (ADDR_BITS)
   ) u_hash (
      .clock      (clock),
      .reset      (reset),
      .hash_req   (hash_req),
      .slot_valid (slot_valid),
      .slot       (slot)
   );

   lpht_mem #(
      .SLOT_BITS (ADDR_BITS),
      .WORD_BITS (WORD_BITS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (addr_in),
      .rd_data (rd_data)
   );

   // next state and datapath control
   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      hole_in      = hole_ff;
      count_in     = count_ff;
      ent_in       = ent_ff;
      status_in    = status_ff;
      found_in     = found_ff;
      wr_en        = 1'b0;
      wr_addr      = addr_ff;
      wr_data      = {1'b1, key_ff, pay_ff};
      hash_req     = '{valid: 1'b0, key: req_key};
      rsp_load     = 1'b0;

      case (state_ff)
         // zero the used bits one slot a cycle
         lpht_pkg::ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_data = '0;
            addr_in = addr_ff + 1'b1;
            if (addr_ff == LAST_SLOT) begin
               state_in = lpht_pkg::ST_IDLE;
            end
         end
         lpht_pkg::ST_IDLE: begin
            if (accept) begin
               hash_req.valid = 1'b1;
               found_in       = '0;
               status_in      = lpht_pkg::STS_NOT_FOUND;
               state_in       = lpht_pkg::ST_HASH;
            end
         end
         // wait for the home slot, then read it (a full insert or an unused action ends here)
         lpht_pkg::ST_HASH: begin
            if (slot_valid) begin
               addr_in = slot;
               if (action_ff == lpht_pkg::ACT_INSERT) begin
                  if (count_ff >= HALF_LOAD) begin
                     status_in = lpht_pkg::STS_FULL;
                     state_in  = lpht_pkg::ST_DONE;
                  end else begin
                     state_in = lpht_pkg::ST_PROBE;
                  end
               end else if (action_ff == lpht_pkg::ACT_LOOKUP ||
                            action_ff == lpht_pkg::ACT_REMOVE) begin
                  state_in = lpht_pkg::ST_PROBE;
               end else begin
                  state_in = lpht_pkg::ST_DONE;
               end
            end
         end
         // one slot per cycle along the probe path
         lpht_pkg::ST_PROBE: begin
            if (action_ff == lpht_pkg::ACT_INSERT) begin
               if (rd_used) begin
                  addr_in = addr_ff + 1'b1;
               end else begin
                  wr_en     = 1'b1;
                  count_in  = count_ff + 1'b1;
                  status_in = lpht_pkg::STS_OK;
                  state_in  = lpht_pkg::ST_DONE;
               end
            end else if (!rd_used) begin
               state_in = lpht_pkg::ST_DONE;
            end else if (rd_key == key_ff) begin
               found_in  = lpht_pkg::OUT_PAY_BITS'(rd_pay);
               status_in = lpht_pkg::STS_OK;
               if (action_ff == lpht_pkg::ACT_REMOVE) begin
                  hole_in  = addr_ff;
                  addr_in  = addr_ff + 1'b1;
                  state_in = lpht_pkg::ST_SH_READ;
               end else begin
                  state_in = lpht_pkg::ST_DONE;
               end
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         // backward shift: look at the next slot of the cluster
         lpht_pkg::ST_SH_READ: begin
            if (rd_used) begin
               ent_in         = rd_data;
               hash_req.valid = 1'b1;
               hash_req.key   = rd_key;
               state_in       = lpht_pkg::ST_SH_HASH;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = hole_ff;
               wr_data  = '0;
               count_in = count_ff - 1'b1;
               state_in = lpht_pkg::ST_DONE;
            end
         end
         // move the entry into the hole unless it must stay
         lpht_pkg::ST_SH_HASH: begin
            if (slot_valid) begin
               if (!stays) begin
                  wr_en   = 1'b1;
                  wr_addr = hole_ff;
                  wr_data = ent_ff;
                  hole_in = addr_ff;
               end
               addr_in  = addr_ff + 1'b1;
               state_in = lpht_pkg::ST_SH_READ;
            end
         end
         // hand the result to the output register
         lpht_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = lpht_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lpht_pkg::ST_CLEAR;
            addr_in  = '0;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lpht_pkg::ST_CLEAR;
         addr_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      hole_ff   <= hole_in;
      ent_ff    <= ent_in;
      status_ff <= status_in;
      found_ff  <= found_in;
      if (accept) begin
         action_ff <= req_tuser;
         key_ff    <= req_key;
         pay_ff    <= PAYLOAD_BITS'(req_payload);
      end
      if (rsp_load) begin
         rsp_status_ff  <= status_ff;
         rsp_found_ff   <= found_ff;
         rsp_entries_ff <= lpht_pkg::ENTRY_BITS'(count_ff);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {
      (lpht_pkg::RSP_DATA_BITS - lpht_pkg::OUT_PAY_BITS - lpht_pkg::ENTRY_BITS)'(0),
      rsp_entries_ff, rsp_found_ff};

endmodule

FILE: tb/tb_linear_probe_hash_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_linear_probe_hash_table
// Self-checking bench for the linear probing hash table. A directed table
// walks empty, key and payload extremes, key zero, duplicate keys and the
// unused action code. Random phases then fill, drain and churn the table,
// with keys bunched on the slot wrap point to build long clusters. Every
// response is checked field by field against a software copy of the table,
// or a hand-fixed answer for typed rows. Both sides idle at random, and the
// response side holds off once for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
module tb_linear_probe_hash_table;

   localparam int SLOTS         = lpht_pkg::DEF_TABLE_SLOTS;
   localparam int ACTION_BITS   = lpht_pkg::ACTION_BITS;
   localparam int KEY_BITS      = lpht_pkg::KEY_BITS;
   localparam int STATUS_BITS   = lpht_pkg::STATUS_BITS;
   localparam int OUT_PAY_BITS  = lpht_pkg::OUT_PAY_BITS;
   localparam int ENTRY_BITS    = lpht_pkg::ENTRY_BITS;
   localparam int REQ_DATA_BITS = lpht_pkg::REQ_DATA_BITS;
   localparam int RSP_DATA_BITS = lpht_pkg::RSP_DATA_BITS;
   localparam int RANDOM_ITEMS = 1726;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = 150;
   localparam int HOLD_AT      = 500;
   localparam int HOLD_CYCLES  = 400;
   localparam int QUIET_FROM   = 900;
   localparam int QUIET_TO     = 1200;

   // action code the block does not define
   localparam logic [ACTION_BITS-1:0] ACT_UNUSED = 2'd3;

   localparam logic [KEY_BITS-1:0] KEY_ONES = 48'hFFFF_FFFF_FFFF;

   typedef struct packed {
      logic [STATUS_BITS-1:0]  status;
      logic [OUT_PAY_BITS-1:0] found;
      logic [ENTRY_BITS-1:0]   entries;
   } answer_type;

   typedef struct packed {
      logic [ACTION_BITS-1:0]  action;
      logic [KEY_BITS-1:0]     key;
      logic [OUT_PAY_BITS-1:0] payload;
      logic                    typed;   // answer below is fixed by hand
      answer_type              answer;
   } plan_row_type;

   localparam int PLAN_ROWS = 24;

   // directed requests; rows with typed=0 are checked against the table copy
   plan_row_type plan [0:PLAN_ROWS-1] = '{
      '{lpht_pkg::ACT_LOOKUP, 48'd1,    32'h0,        1'b1,
        '{lpht_pkg::STS_NOT_FOUND, 32'h0, 6'd0}},
      '{lpht_pkg::ACT_REMOVE, KEY_ONES, 32'h0,        1'b1,
        '{lpht_pkg::STS_NOT_FOUND, 32'h0, 6'd0}},
      '{ACT_UNUSED,           48'd1,    32'hFFFFFFFF, 1'b1,
        '{lpht_pkg::STS_NOT_FOUND, 32'h0, 6'd0}},
      '{lpht_pkg::ACT_INSERT, KEY_ONES, 32'hFFFFFFFF, 1'b1,
        '{lpht_pkg::STS_OK, 32'h0, 6'd1}},
      '{lpht_pkg::ACT_INSERT, 48'd1,    32'h0,        1'b1,
        '{lpht_pkg::STS_OK, 32'h0, 6'd2}},
      '{lpht_pkg::ACT_LOOKUP, KEY_ONES, 32'h0,        1'b1,
        '{lpht_pkg::STS_OK, 32'hFFFFFFFF, 6'd2}},
      '{lpht_pkg::ACT_LOOKUP, 48'd1,    32'h0,        1'b1,
        '{lpht_pkg::STS_OK, 32'h0, 6'd2}},
      '{lpht_pkg::ACT_INSERT, 48'd0,    32'hA5A5A5A5, 1'b1,
        '{lpht_pkg::STS_OK, 32'h0, 6'd3}},
      '{lpht_pkg::ACT_LOOKUP, 48'd0,    32'h0,        1'b1,
        '{lpht_pkg::STS_OK, 32'hA5A5A5A5, 6'd3}},
      '{lpht_pkg::ACT_INSERT, 48'd1,    32'h5A5A5A5A, 1'b1,
        '{lpht_pkg::STS_OK, 32'h0, 6'd4}},
      '{lpht_pkg::ACT_LOOKUP, 48'd1,    32'h0,        1'b0,
        '{lpht_pkg::STS_OK, 32'h0, 6'd0}},
      '{lpht_pkg::ACT_REMOVE, 48'd1,    32'h0,        1'b0,
        '{lpht_pkg::STS_OK, 32'h0, 6'd0}},
      '{lpht_pkg::ACT_LOOKUP, 48'd1,    32'h0,        1'b0,
        '{lpht_pkg::STS_OK, 32'h0, 6'd0}},
      '{lpht_pkg::ACT_REMOVE, 48'd1,    32'h0,        1'b0,
        '{lpht_pkg::STS_OK, 32'h0, 6'd0}},
      '{lpht_pkg::ACT_REMOVE, 48'd1,    32'h0,        1'b1,
        '{lpht_pkg::STS_NOT_FOUND, 32'h0, 6'd2}},
      '{ACT_UNUSED,           48'd0,    32'h0,        1'b1,
        '{lpht_pkg::STS_NOT_FOUND, 32'h0, 6'd2}},
      '{lpht_pkg::ACT_INSERT, 48'h8000_0000_0000, 32'h80000000, 1'b1,
        '{lpht_pkg::STS_OK, 32'h0, 6'd3}},
      '{lpht_pkg::ACT_INSERT, 48'h5555_5555_5555, 32'h12345678, 1'b1,
        '{lpht_pkg::STS_OK, 32'h0, 6'd4}},
      '{lpht_pkg::ACT_INSERT, 48'hAAAA_AAAA_AAAA, 32'h87654321, 1'b1,
        '{lpht_pkg::STS_OK, 32'h0, 6'd5}},
      '{lpht_pkg::ACT_REMOVE, 48'd0,    32'h0,        1'b1,
        '{lpht_pkg::STS_OK, 32'hA5A5A5A5, 6'd4}},
      '{lpht_pkg::ACT_LOOKUP, 48'hAAAA_AAAA_AAAA, 32'h0, 1'b0,
        '{lpht_pkg::STS_OK, 32'h0, 6'd0}},
      '{lpht_pkg::ACT_REMOVE, KEY_ONES, 32'h0,        1'b1,
        '{lpht_pkg::STS_OK, 32'hFFFFFFFF, 6'd3}},
      '{lpht_pkg::ACT_REMOVE, 48'h8000_0000_0000, 32'h0, 1'b1,
        '{lpht_pkg::STS_OK, 32'h80000000, 6'd2}},
      '{lpht_pkg::ACT_LOOKUP, 48'h5555_5555_5555, 32'h0, 1'b0,
        '{lpht_pkg::STS_OK, 32'h0, 6'd0}}
   };

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata  = '0;
   logic [ACTION_BITS-1:0]   req_tuser  = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic [STATUS_BITS-1:0]   rsp_tuser;

   // software copy of the table
   logic [KEY_BITS-1:0]     slot_key [SLOTS];
   logic [OUT_PAY_BITS-1:0] slot_pay [SLOTS];
   bit                      slot_full [SLOTS];
   int                      stored = 0;

   answer_type              pending_answers[$];
   logic [KEY_BITS-1:0]     live_keys[$];

   int accepted   = 0;
   int answered   = 0;
   int fail_count = 0;
   int cycle_count = 0;
   int hold_left  = 0;
   bit hold_done  = 1'b0;
   int n_stored   = 0;
   int n_rejected = 0;
   int n_hits     = 0;
   int n_misses   = 0;
   int n_removed  = 0;

   wire quiet = (accepted >= QUIET_FROM) && (accepted < QUIET_TO);

   linear_probe_hash_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #4 clock = ~clock;

   // home slot: shift, xor, multiply in 64-bit wrap, xor, mask
   function automatic int home_of(input logic [KEY_BITS-1:0] key);
      logic [63:0] k;
      k = {16'b0, key} >> lpht_pkg::HASH_PRE_SHIFT;
      k = k ^ (k >> lpht_pkg::HASH_MIX_SHIFT);
      k = k * {32'b0, lpht_pkg::HASH_MULT};
      k = k ^ (k >> lpht_pkg::HASH_POST_SHIFT);
      return int'(k & 64'(SLOTS - 1));
   endfunction

   function automatic int find_key(input logic [KEY_BITS-1:0] key);
      int i;
      i = home_of(key);
      for (int n = 0; n < SLOTS; n++) begin
         if (!slot_full[i])
            return -1;
         if (slot_key[i] == key)
            return i;
         i = (i + 1) % SLOTS;
      end
      return -1;
   endfunction

   // backward shift: pull later cluster members into the hole
   function automatic void close_hole(input int start);
      int hole;
      int j;
      int h;
      bit stays;
      hole = start;
      j = start;
      for (int n = 0; n < SLOTS; n++) begin
         j = (j + 1) % SLOTS;
         if (!slot_full[j])
            break;
         h = home_of(slot_key[j]);
         if (hole <= j)
            stays = (hole < h) && (h <= j);
         else
            stays = (hole < h) || (h <= j);
         if (!stays) begin
            slot_key[hole] = slot_key[j];
            slot_pay[hole] = slot_pay[j];
            hole = j;
         end
      end
      slot_full[hole] = 1'b0;
      slot_key[hole]  = '0;
      slot_pay[hole]  = '0;
      if (stored > 0)
         stored--;
   endfunction

   // apply one request to the table copy and return its answer
   function automatic answer_type hash_table_apply(input logic [ACTION_BITS-1:0] action,
                                                   input logic [KEY_BITS-1:0] key,
                                                   input logic [OUT_PAY_BITS-1:0] payload);
      answer_type a;
      int i;
      int s;
      a.status = lpht_pkg::STS_NOT_FOUND;
      a.found  = '0;
      case (action)
         lpht_pkg::ACT_INSERT: begin
            a.status = lpht_pkg::STS_FULL;
            if ((stored + 1) * 2 <= SLOTS) begin
               i = home_of(key);
               for (int n = 0; n < SLOTS && slot_full[i]; n++)
                  i = (i + 1) % SLOTS;
               if (!slot_full[i]) begin
                  slot_full[i] = 1'b1;
                  slot_key[i]  = key;
                  slot_pay[i]  = payload;
                  stored++;
                  a.status = lpht_pkg::STS_OK;
               end
            end
         end
         lpht_pkg::ACT_LOOKUP, lpht_pkg::ACT_REMOVE: begin
            s = find_key(key);
            if (s >= 0) begin
               a.found  = slot_pay[s];
               a.status = lpht_pkg::STS_OK;
               if (action == lpht_pkg::ACT_REMOVE)
                  close_hole(s);
            end
         end
         default: ;
      endcase
      a.entries = ENTRY_BITS'(stored);
      return a;
   endfunction

   function automatic logic [KEY_BITS-1:0] any_key();
      return {16'($urandom_range(16'hFFFF)), 32'($urandom)};
   endfunction

   // random key whose home slot falls in a narrow band around the wrap point
   function automatic logic [KEY_BITS-1:0] bunched_key();
      logic [KEY_BITS-1:0] k;
      k = any_key();
      for (int n = 0; n < 400; n++) begin
         if (((home_of(k) - (SLOTS - 2)) & (SLOTS - 1)) < 4)
            break;
         k = any_key();
      end
      return k;
   endfunction

   // offer one request; typed answers override the table copy
   task automatic send_request(input logic [ACTION_BITS-1:0] action,
                               input logic [KEY_BITS-1:0] key,
                               input logic [OUT_PAY_BITS-1:0] payload,
                               input logic typed,
                               input answer_type typed_answer);
      answer_type a;
      @(negedge clock);
      while (!quiet && $urandom_range(99) < 9) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {payload, key};
      req_tuser  <= action;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      a = hash_table_apply(action, key, payload);
      pending_answers.push_back(typed ? typed_answer : a);
      accepted++;
      // keep the pool of live keys and the coverage tallies current
      case (action)
         lpht_pkg::ACT_INSERT: begin
            if (a.status == lpht_pkg::STS_OK) begin
               live_keys.push_back(key);
               n_stored++;
            end else begin
               n_rejected++;
            end
         end
         lpht_pkg::ACT_LOOKUP, lpht_pkg::ACT_REMOVE: begin
            if (a.status == lpht_pkg::STS_OK) begin
               n_hits++;
               if (action == lpht_pkg::ACT_REMOVE) begin
                  n_removed++;
                  foreach (live_keys[i])
                     if (live_keys[i] == key) begin
                        live_keys.delete(i);
                        break;
                     end
               end
            end else begin
               n_misses++;
            end
         end
         default: ;
      endcase
   endtask

   function automatic void report(input string field, input logic [63:0] want,
                                  input logic [63:0] got);
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
   endfunction

   // response side: random stalls plus one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else if (!hold_done && accepted >= HOLD_AT) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= quiet || ($urandom_range(99) >= 9);
      end
   end

   // response checker
   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         answered++;
         if (pending_answers.size() == 0) begin
            report("unexpected response", 64'h0, {rsp_tuser, rsp_tdata});
         end else begin
            want = pending_answers.pop_front();
            if (rsp_tuser !== want.status)
               report("status", want.status, rsp_tuser);
            if (rsp_tdata[OUT_PAY_BITS-1:0] !== want.found)
               report("found_payload", want.found, rsp_tdata[OUT_PAY_BITS-1:0]);
            if (rsp_tdata[OUT_PAY_BITS +: ENTRY_BITS] !== want.entries)
               report("entries", want.entries, rsp_tdata[OUT_PAY_BITS +: ENTRY_BITS]);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, pending_answers.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // stimulus
   initial begin
      int sent;
      int mode;
      int phase_len;
      int r;
      logic [ACTION_BITS-1:0] act;
      logic [KEY_BITS-1:0] key;
      answer_type none;

      none = '0;
      foreach (slot_full[i]) begin
         slot_full[i] = 1'b0;
         slot_key[i]  = '0;
         slot_pay[i]  = '0;
      end
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      foreach (plan[i])
         send_request(plan[i].action, plan[i].key, plan[i].payload,
                      plan[i].typed, plan[i].answer);

      // random phases: fill, drain, churn, bunched clusters
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         mode = $urandom_range(3);
         phase_len = $urandom_range(20, 80);
         for (int n = 0; n < phase_len && sent < RANDOM_ITEMS; n++) begin
            r = $urandom_range(99);
            if (r < 3)
               act = ACT_UNUSED;
            else begin
               r = $urandom_range(99);
               case (mode)
                  0:       act = (r < 80) ? lpht_pkg::ACT_INSERT :
                                 (r < 90) ? lpht_pkg::ACT_LOOKUP : lpht_pkg::ACT_REMOVE;
                  1:       act = (r < 10) ? lpht_pkg::ACT_INSERT :
                                 (r < 35) ? lpht_pkg::ACT_LOOKUP : lpht_pkg::ACT_REMOVE;
                  default: act = (r < 40) ? lpht_pkg::ACT_INSERT :
                                 (r < 70) ? lpht_pkg::ACT_LOOKUP : lpht_pkg::ACT_REMOVE;
               endcase
            end
            r = $urandom_range(99);
            if (act == lpht_pkg::ACT_INSERT) begin
               if (r < 10 && live_keys.size() > 0)
                  key = live_keys[$urandom_range(live_keys.size() - 1)];
               else if (mode == 3 || r < 25)
                  key = bunched_key();
               else
                  key = any_key();
            end else if (r < 80 && live_keys.size() > 0) begin
               key = live_keys[$urandom_range(live_keys.size() - 1)];
            end else begin
               key = any_key();
            end
            send_request(act, key, $urandom, 1'b0, none);
            sent++;
         end
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      // drain, then let the block settle
      while (pending_answers.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d requests, %0d responses: %0d stored, %0d rejected at half load,",
               accepted, answered, n_stored, n_rejected);
      $display("%0d hits (%0d removals with backward shift), %0d misses, %0d cycles",
               n_hits, n_removed, n_misses, cycle_count);
      if (fail_count == 0 && pending_answers.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
